// File: rtl/utu_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned PART_W  = 10;
    localparam int unsigned PEND_W  = 2;

    // Lead and continuation byte classes.
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1f;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0f;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3f;

    // Continuation bytes still expected.
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    localparam logic [UNIT_W-1:0] COUNT_MAX = 16'hffff;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } t_byte_item;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_error;
        logic              is_last;
        logic [UNIT_W-1:0] unit_count;
    } t_unit_item;

endpackage

// File: rtl/utu_if.sv
// Valid/ready channel interfaces for the byte input and the code unit output.
`timescale 1ns / 1ps

interface utu_byte_if import utu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;

    modport source (output valid, data_byte, end_of_string, input ready);
    modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface utu_unit_if import utu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              is_error;
    logic              is_last;
    logic [UNIT_W-1:0] unit_count;

    modport source (output valid, code_unit, is_error, is_last, unit_count, input ready);
    modport sink   (input valid, code_unit, is_error, is_last, unit_count, output ready);
endinterface

// File: rtl/utf8_to_utf16_decoder.sv
// Top level of the modified UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

// Decodes a byte stream of modified UTF-8 strings (one, two or three byte
// sequences, last byte flagged by end_of_string) into 16-bit code units with a
// saturating per-string unit count. One byte is taken every clock unless the
// result register holds a result not yet read; a completing byte passes from
// the input register through the decode logic into the result register. Throughput
// is bound by the string state register update. A malformed string yields
// no units after the fault and one error result, flagged last, on its final
// byte; every unit already delivered for that string must then be dropped.
// Other bytes that complete no unit produce no result.
module utf8_to_utf16_decoder import utu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utu_byte_if.sink   i_byte,
    utu_unit_if.source o_unit
);

    logic       w_valid;
    t_byte_item w_item;
    logic       w_take;

    utu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    utu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_unit  (o_unit)
    );

endmodule

// File: rtl/utu_in_reg.sv
// Input register stage: holds one byte request until the decoder takes it.
`timescale 1ns / 1ps

module utu_in_reg import utu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utu_byte_if.sink   i_byte,
    output logic       o_valid,
    output t_byte_item o_item,
    input  logic       i_take
);

    logic       r_valid;
    t_byte_item r_item;
    logic       w_load;

    assign i_byte.ready = !r_valid || i_take;
    assign w_load       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.data_byte     <= i_byte.data_byte;
            r_item.end_of_string <= i_byte.end_of_string;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/utu_decode.sv
// Decode stage: string state, byte classification and the result register.
`timescale 1ns / 1ps

module utu_decode import utu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_byte_item i_item,
    output logic       o_take,
    utu_unit_if.source o_unit
);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [PART_W-1:0] r_partial, n_partial;
    logic              r_err, n_err;
    logic [UNIT_W-1:0] r_units, n_units;
    logic              r_out_valid;
    t_unit_item        r_out, n_out;
    logic              w_emit;
    logic              w_have;
    logic [UNIT_W-1:0] w_unit;
    logic [BYTE_W-1:0] w_b;
    logic              w_last;

    assign w_b    = i_item.data_byte;
    assign w_last = i_item.end_of_string;
    assign o_take = i_valid && (!r_out_valid || o_unit.ready);

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_err     = r_err;
        n_units   = r_units;
        w_have    = 1'b0;
        w_unit    = '0;
        w_emit    = 1'b0;
        n_out     = '0;

        if (!r_err) begin
            if (r_pending == PEND_NONE) begin
                priority if ((w_b & ASCII_MASK) == '0) begin
                    w_unit = {8'd0, w_b};
                    w_have = 1'b1;
                end else if ((w_b & LEAD2_MASK) == LEAD2_CODE) begin
                    n_partial = {5'd0, w_b[4:0] & LEAD2_BITS[4:0]};
                    n_pending = PEND_ONE;
                end else if ((w_b & LEAD3_MASK) == LEAD3_CODE) begin
                    n_partial = {6'd0, w_b[3:0] & LEAD3_BITS[3:0]};
                    n_pending = PEND_TWO;
                end else begin
                    n_err = 1'b1;
                end
            end else if ((w_b & CONT_MASK) != CONT_CODE) begin
                n_err = 1'b1;
            end else if (r_pending == PEND_TWO) begin
                n_partial = {r_partial[3:0], w_b[5:0] & CONT_BITS[5:0]};
                n_pending = PEND_ONE;
            end else begin
                // pending of one, or the unreachable code three
                w_unit    = {r_partial, w_b[5:0] & CONT_BITS[5:0]};
                n_partial = '0;
                n_pending = PEND_NONE;
                w_have    = 1'b1;
            end
        end

        // string closed inside a sequence
        if (w_last && !n_err && n_pending != PEND_NONE) begin
            n_err = 1'b1;
        end

        if (n_err) begin
            if (w_last) begin
                w_emit         = 1'b1;
                n_out.is_error = 1'b1;
                n_out.is_last  = 1'b1;
            end
        end else if (w_have) begin
            if (r_units != COUNT_MAX) begin
                n_units = r_units + 16'd1;
            end
            w_emit           = 1'b1;
            n_out.code_unit  = w_unit;
            n_out.is_last    = w_last;
            n_out.unit_count = n_units;
        end

        if (w_last && w_emit) begin
            n_pending = PEND_NONE;
            n_partial = '0;
            n_err     = 1'b0;
            n_units   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= PEND_NONE;
            r_partial <= '0;
            r_err     <= 1'b0;
            r_units   <= '0;
        end else if (o_take) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_err     <= n_err;
            r_units   <= n_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_unit.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_unit.valid      = r_out_valid;
    assign o_unit.code_unit  = r_out.code_unit;
    assign o_unit.is_error   = r_out.is_error;
    assign o_unit.is_last    = r_out.is_last;
    assign o_unit.unit_count = r_out.unit_count;

    a_pending_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("pending count reached an illegal code");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && w_last |=> r_pending == PEND_NONE && !r_err && r_units == '0)
        else $error("string state not cleared after final byte");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_error |-> r_out.is_last && r_out.code_unit == '0
            && r_out.unit_count == '0)
        else $error("malformed error result");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.is_error |-> r_out.unit_count != '0)
        else $error("good result with zero unit count");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_err && !w_last |=> $stable(r_out_valid) || !r_out_valid)
        else $error("result raised while error is pending");

endmodule
